// ----- src/s5scan_pkg.sv -----
// Shared types, constants and helpers for the ACPI S5 sleep-type scanner.
`default_nettype none

package s5scan_pkg;

    localparam logic [31:0] SIG_RESET        = 32'h5444_5344;
    localparam logic [5:0]  HEADER_BYTES     = 6'd36;
    localparam logic [5:0]  NAME_END_MIN     = 6'd39;
    localparam logic [5:0]  POS_MAX          = 6'd63;
    localparam logic [7:0]  NAME_OP          = 8'h08;
    localparam logic [7:0]  PACKAGE_OP       = 8'h12;
    localparam logic [7:0]  BYTE_PREFIX      = 8'h0A;
    localparam logic [7:0]  PKGLEN_MASK      = 8'hC0;
    localparam logic [7:0]  CHAR_UNDERSCORE  = 8'h5F;
    localparam logic [7:0]  CHAR_FIVE        = 8'h35;
    localparam logic [7:0]  CHAR_S           = 8'h53;
    localparam logic [7:0]  CHAR_BACKSLASH   = 8'h5C;
    localparam int unsigned SLP_TYP_SHIFT    = 10;
    localparam logic [15:0] SLP_EN_WORD      = 16'h2000;
    localparam int unsigned QUEUE_DEPTH      = 4;

    typedef enum logic [2:0] {
        PH_SCAN   = 3'd0,
        PH_PKGOP  = 3'd1,
        PH_PKGLEN = 3'd2,
        PH_SKIP   = 3'd3,
        PH_TYPEA  = 3'd4,
        PH_TYPEB  = 3'd5,
        PH_DONE   = 3'd6,
        PH_FAIL   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIG   = 3'd1,
        ST_BAD_SUM   = 3'd2,
        ST_NO_S5     = 3'd3,
        ST_PARSE_ERR = 3'd4
    } status_t;

    // One classified table byte handed from the front end to the parser.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       name_hit;    // "_S5_" completes here, past the header
        logic       name_ok;     // preceded by name op, optionally with root prefix
        logic       sig_bad;     // valid on the last byte only
        logic       sum_bad;     // valid on the last byte only
    } token_t;

    function automatic logic [15:0] control_word(input logic [7:0] slp_type);
        logic [15:0] word;
        word = {slp_type[5:0], 10'b0} | SLP_EN_WORD;
        return word;
    endfunction

endpackage

`default_nettype wire

// ----- src/s5scan_front.sv -----
// Front end: signature check, byte sum and "_S5_" name detection per table byte.
`default_nettype none

module s5scan_front
    import s5scan_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic [7:0]  table_byte,
    input  wire logic        final_byte,
    input  wire logic        accept,
    output token_t           token
);

    logic [31:0] sig_reg;
    logic [5:0]  pos_reg;
    logic [7:0]  sum_reg;
    logic [7:0]  recent_reg [5];
    logic        sig_match_reg;

    logic        sig_match_next;
    logic [7:0]  sum_next;
    logic [7:0]  sig_byte;

    always_comb
    begin
        sig_byte       = sig_reg[{pos_reg[1:0], 3'b000} +: 8];
        sig_match_next = sig_match_reg;
        if (pos_reg < 6'd4 && table_byte != sig_byte)
        begin
            sig_match_next = 1'b0;
        end
        sum_next = sum_reg + table_byte;

        token.data     = table_byte;
        token.last     = final_byte;
        token.name_hit = (pos_reg >= NAME_END_MIN) && (table_byte == CHAR_UNDERSCORE)
                         && (recent_reg[0] == CHAR_FIVE) && (recent_reg[1] == CHAR_S)
                         && (recent_reg[2] == CHAR_UNDERSCORE);
        token.name_ok  = (recent_reg[3] == NAME_OP)
                         || (recent_reg[4] == NAME_OP && recent_reg[3] == CHAR_BACKSLASH);
        token.sig_bad  = !sig_match_next || (pos_reg < 6'd3);
        token.sum_bad  = (sum_next != 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_reg <= SIG_RESET;
        end
        else if (cfg_wr_en)
        begin
            sig_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            sig_match_reg <= 1'b1;
            for (int i = 0; i < 5; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (final_byte)
            begin
                // start over for the next table
                pos_reg       <= '0;
                sum_reg       <= '0;
                sig_match_reg <= 1'b1;
                for (int i = 0; i < 5; i++)
                begin
                    recent_reg[i] <= '0;
                end
            end
            else
            begin
                if (pos_reg != POS_MAX)
                begin
                    pos_reg <= pos_reg + 6'd1;
                end
                sum_reg       <= sum_next;
                sig_match_reg <= sig_match_next;
                recent_reg[0] <= table_byte;
                for (int i = 1; i < 5; i++)
                begin
                    recent_reg[i] <= recent_reg[i-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/s5scan_fifo.sv -----
// Short token queue between the front end and the AML parser.
`default_nettype none

module s5scan_fifo
    import s5scan_pkg::*;
#(
    parameter int unsigned Depth = QUEUE_DEPTH
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire token_t push_data,
    output logic        full,
    input  wire logic   pop,
    output token_t      pop_data,
    output logic        not_empty
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    token_t          store_reg [Depth];
    logic [PtrW-1:0] wptr_reg;
    logic [PtrW-1:0] rptr_reg;
    logic [CntW-1:0] count_reg;

    assign full      = (count_reg == FullCnt);
    assign not_empty = (count_reg != '0);
    assign pop_data  = store_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == LastPtr) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == LastPtr) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/s5scan_back.sv -----
// Back end: AML parse of the _S5_ package and the registered result request.
`default_nettype none

module s5scan_back
    import s5scan_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire token_t token,
    input  wire logic   token_valid,
    output logic        token_pop,
    output logic [2:0]  parse_status,
    output logic [15:0] pm1a_control_word,
    output logic [15:0] pm1b_control_word,
    output logic        out_valid,
    input  wire logic   out_stall
);

    phase_t      phase_reg, phase_next, phase_work;
    logic [1:0]  skip_reg, skip_next, skip_work;
    logic [7:0]  type_a_reg, type_a_next, type_a_work;
    logic [7:0]  type_b_reg, type_b_next, type_b_work;
    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;
    logic [15:0] word_a_reg, word_a_next;
    logic [15:0] word_b_reg, word_b_next;

    always_comb
    begin
        phase_work  = phase_reg;
        skip_work   = skip_reg;
        type_a_work = type_a_reg;
        type_b_work = type_b_reg;

        case (phase_reg)
            PH_SCAN:
            begin
                if (token.name_hit)
                begin
                    phase_work = token.name_ok ? PH_PKGOP : PH_FAIL;
                end
            end
            PH_PKGOP:
            begin
                phase_work = (token.data == PACKAGE_OP) ? PH_PKGLEN : PH_FAIL;
            end
            PH_PKGLEN:
            begin
                // follow-on length bytes, then the element count
                skip_work  = 2'((token.data & PKGLEN_MASK) >> 6);
                phase_work = PH_SKIP;
            end
            PH_SKIP:
            begin
                if (skip_reg == 2'd0)
                begin
                    phase_work = PH_TYPEA;
                end
                else
                begin
                    skip_work = skip_reg - 2'd1;
                end
            end
            PH_TYPEA, PH_TYPEB:
            begin
                // drop one byte prefix ahead of each value
                if (skip_reg == 2'd0 && token.data == BYTE_PREFIX)
                begin
                    skip_work = 2'd1;
                end
                else
                begin
                    skip_work = 2'd0;
                    if (phase_reg == PH_TYPEA)
                    begin
                        type_a_work = token.data;
                        phase_work  = PH_TYPEB;
                    end
                    else
                    begin
                        type_b_work = token.data;
                        phase_work  = PH_DONE;
                    end
                end
            end
            default:
            begin
                phase_work = phase_reg;
            end
        endcase

        if (token.sig_bad)
        begin
            status_next = ST_BAD_SIG;
        end
        else if (token.sum_bad)
        begin
            status_next = ST_BAD_SUM;
        end
        else if (phase_work == PH_SCAN)
        begin
            status_next = ST_NO_S5;
        end
        else if (phase_work != PH_DONE)
        begin
            status_next = ST_PARSE_ERR;
        end
        else
        begin
            status_next = ST_OK;
        end

        // hold the last byte until the result register is free
        token_pop = token_valid && (!token.last || !out_valid_reg || !out_stall);

        phase_next     = phase_reg;
        skip_next      = skip_reg;
        type_a_next    = type_a_reg;
        type_b_next    = type_b_reg;
        out_valid_next = out_valid_reg && out_stall;
        word_a_next    = word_a_reg;
        word_b_next    = word_b_reg;

        if (token_pop)
        begin
            if (token.last)
            begin
                phase_next     = PH_SCAN;
                skip_next      = '0;
                type_a_next    = '0;
                type_b_next    = '0;
                out_valid_next = 1'b1;
                word_a_next    = (status_next == ST_OK) ? control_word(type_a_work) : '0;
                word_b_next    = (status_next == ST_OK) ? control_word(type_b_work) : '0;
            end
            else
            begin
                phase_next  = phase_work;
                skip_next   = skip_work;
                type_a_next = type_a_work;
                type_b_next = type_b_work;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SCAN;
            skip_reg      <= '0;
            type_a_reg    <= '0;
            type_b_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            type_a_reg    <= type_a_next;
            type_b_reg    <= type_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (token_pop && token.last)
        begin
            status_reg <= status_next;
        end
        word_a_reg <= word_a_next;
        word_b_reg <= word_b_next;
    end

    assign parse_status      = status_reg;
    assign pm1a_control_word = word_a_reg;
    assign pm1b_control_word = word_b_reg;
    assign out_valid         = out_valid_reg;

endmodule

`default_nettype wire

// ----- src/acpi_s5_sleep_type_scanner.sv -----
// Result: out_valid is registered, set once the parser pops the table's last byte.
// Throughput: one table byte per cycle while in_stall is low; the front end classifies
// each byte and the parser takes one queued byte per cycle, held only by a stalled result.
// Reset: asynchronous, active low; clears all parse state, empties the queue and sets the
// signature register to "DSDT". No clearing pass; bytes are taken from the first cycle.
`default_nettype none

module acpi_s5_sleep_type_scanner
    import s5scan_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic [7:0]  table_byte,
    input  wire logic        final_byte,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic [2:0]       parse_status,
    output logic [15:0]      pm1a_control_word,
    output logic [15:0]      pm1b_control_word,
    output logic             out_valid,
    input  wire logic        out_stall
);

    token_t front_token;
    token_t back_token;
    logic   queue_full;
    logic   queue_not_empty;
    logic   queue_pop;
    logic   accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    s5scan_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .table_byte  (table_byte),
        .final_byte  (final_byte),
        .accept      (accept),
        .token       (front_token)
    );

    s5scan_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_token),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (back_token),
        .not_empty (queue_not_empty)
    );

    s5scan_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .token             (back_token),
        .token_valid       (queue_not_empty),
        .token_pop         (queue_pop),
        .parse_status      (parse_status),
        .pm1a_control_word (pm1a_control_word),
        .pm1b_control_word (pm1b_control_word),
        .out_valid         (out_valid),
        .out_stall         (out_stall)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the ACPI S5 sleep-type scanner.
`default_nettype none

module tb
    import s5scan_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESULT_LATENCY = 2;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 3;
    localparam int QUIET_LIMIT    = 3000;
    localparam int RANDOM_TABLES  = 3;

    typedef logic [7:0] byte_list_t[$];

    typedef struct {
        status_t     status;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } verdict_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic [7:0]  table_byte  = '0;
    logic        final_byte  = 1'b0;
    logic        in_valid    = 1'b0;
    logic        out_stall   = 1'b0;
    logic        in_stall;
    logic [2:0]  parse_status;
    logic [15:0] pm1a_control_word;
    logic [15:0] pm1b_control_word;
    logic        out_valid;

    acpi_s5_sleep_type_scanner u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .table_byte        (table_byte),
        .final_byte        (final_byte),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .parse_status      (parse_status),
        .pm1a_control_word (pm1a_control_word),
        .pm1b_control_word (pm1b_control_word),
        .out_valid         (out_valid),
        .out_stall         (out_stall)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Scanner state as the testbench sees it
    logic [31:0] signature_reg = SIG_RESET;
    logic [5:0]  byte_pos;
    logic [7:0]  byte_sum;
    logic [7:0]  history [6];
    phase_t      phase;
    logic [1:0]  skip_cnt;
    logic [7:0]  type_a;
    logic [7:0]  type_b;
    logic        sig_ok;

    verdict_t    pending_verdicts[$];
    byte_list_t  table_image;
    int          error_count   = 0;
    int          quiet_cycles  = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    function automatic void reset_scan();
        byte_pos = '0;
        byte_sum = '0;
        foreach (history[i]) history[i] = '0;
        phase    = PH_SCAN;
        skip_cnt = '0;
        type_a   = '0;
        type_b   = '0;
        sig_ok   = 1'b1;
    endfunction

    function automatic logic [15:0] pm1_word(input logic [7:0] slp);
        return ({10'b0, slp[5:0]} << SLP_TYP_SHIFT) | SLP_EN_WORD;
    endfunction

    // Advance the scanner by one accepted byte; queue a verdict on the last one
    function automatic void scan_byte(input logic [7:0] b, input logic last);
        logic [5:0] pos;
        verdict_t   v;
        pos = byte_pos;
        if (pos < 6'd4 && b != signature_reg[{pos[1:0], 3'b000} +: 8])
            sig_ok = 1'b0;
        byte_sum = byte_sum + b;
        case (phase)
            PH_SCAN:
            begin
                if (pos >= NAME_END_MIN && b == CHAR_UNDERSCORE && history[0] == CHAR_FIVE &&
                    history[1] == CHAR_S && history[2] == CHAR_UNDERSCORE)
                begin
                    if (history[3] == NAME_OP ||
                        (history[4] == NAME_OP && history[3] == CHAR_BACKSLASH))
                        phase = PH_PKGOP;
                    else
                        phase = PH_FAIL;
                end
            end
            PH_PKGOP: phase = (b == PACKAGE_OP) ? PH_PKGLEN : PH_FAIL;
            PH_PKGLEN:
            begin
                skip_cnt = b[7:6];
                phase    = PH_SKIP;
            end
            PH_SKIP:
            begin
                if (skip_cnt == 2'd0)
                    phase = PH_TYPEA;
                else
                    skip_cnt = skip_cnt - 2'd1;
            end
            PH_TYPEA, PH_TYPEB:
            begin
                // bit 0 of the skip count marks a dropped byte prefix
                if (skip_cnt == 2'd0 && b == BYTE_PREFIX)
                begin
                    skip_cnt = 2'd1;
                end
                else
                begin
                    skip_cnt = 2'd0;
                    if (phase == PH_TYPEA)
                    begin
                        type_a = b;
                        phase  = PH_TYPEB;
                    end
                    else
                    begin
                        type_b = b;
                        phase  = PH_DONE;
                    end
                end
            end
            default: ;
        endcase
        for (int i = 5; i > 0; i--)
            history[i] = history[i - 1];
        history[0] = b;
        if (byte_pos != POS_MAX)
            byte_pos = byte_pos + 6'd1;
        if (last)
        begin
            if (!sig_ok || pos < 6'd3)
                v.status = ST_BAD_SIG;
            else if (byte_sum != 8'd0)
                v.status = ST_BAD_SUM;
            else if (phase == PH_SCAN)
                v.status = ST_NO_S5;
            else if (phase != PH_DONE)
                v.status = ST_PARSE_ERR;
            else
                v.status = ST_OK;
            v.word_a = (v.status == ST_OK) ? pm1_word(type_a) : 16'd0;
            v.word_b = (v.status == ST_OK) ? pm1_word(type_b) : 16'd0;
            pending_verdicts.push_back(v);
            reset_scan();
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending, status %0d", parse_status));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (parse_status != want.status)
                    report_mismatch($sformatf("parse_status %0d, want %0d",
                                              parse_status, want.status));
                if (pm1a_control_word != want.word_a)
                    report_mismatch($sformatf("pm1a_control_word %h, want %h",
                                              pm1a_control_word, want.word_a));
                if (pm1b_control_word != want.word_b)
                    report_mismatch($sformatf("pm1b_control_word %h, want %h",
                                              pm1b_control_word, want.word_b));
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Table construction
    function automatic void put_noise(input int n);
        for (int i = 0; i < n; i++)
            table_image.push_back(8'($urandom));
    endfunction

    function automatic void put_header();
        for (int i = 0; i < 4; i++)
            table_image.push_back(signature_reg[8 * i +: 8]);
        put_noise(int'(HEADER_BYTES) - 4);
    endfunction

    function automatic void put_name();
        table_image.push_back(CHAR_UNDERSCORE);
        table_image.push_back(CHAR_S);
        table_image.push_back(CHAR_FIVE);
        table_image.push_back(CHAR_UNDERSCORE);
    endfunction

    function automatic void put_s5(input bit root, input logic [1:0] len_bytes,
                                   input bit pfx_a, input logic [7:0] val_a,
                                   input bit pfx_b, input logic [7:0] val_b);
        table_image.push_back(NAME_OP);
        if (root)
            table_image.push_back(CHAR_BACKSLASH);
        put_name();
        table_image.push_back(PACKAGE_OP);
        table_image.push_back({len_bytes, 6'($urandom)});
        put_noise(int'(len_bytes));
        table_image.push_back(8'd2);
        if (pfx_a)
            table_image.push_back(BYTE_PREFIX);
        table_image.push_back(val_a);
        if (pfx_b)
            table_image.push_back(BYTE_PREFIX);
        table_image.push_back(val_b);
    endfunction

    function automatic void trim_to(input int n);
        while (table_image.size() > n)
            void'(table_image.pop_back());
    endfunction

    // Fix the header checksum byte so that all bytes add to zero
    function automatic void seal_checksum();
        logic [7:0] total;
        int         idx;
        total = '0;
        foreach (table_image[i])
            total += table_image[i];
        idx = (table_image.size() > 9) ? 9 : table_image.size() - 1;
        table_image[idx] = table_image[idx] - total;
    endfunction

    // Handshake side
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        table_byte <= b;
        final_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        scan_byte(b, last);
    endtask

    task automatic send_table();
        foreach (table_image[i])
            send_byte(table_image[i], i == table_image.size() - 1);
        table_image.delete();
    endtask

    // Hold off until every pending result is back, then let the pipeline settle
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_signature(input logic [31:0] sig);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sig;
        @(posedge clk);
        signature_reg = sig;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic good_table(input bit root, input logic [1:0] len_bytes,
                              input bit pfx_a, input logic [7:0] val_a,
                              input bit pfx_b, input logic [7:0] val_b);
        put_header();
        put_noise(2);
        put_s5(root, len_bytes, pfx_a, val_a, pfx_b, val_b);
        put_noise(1);
        seal_checksum();
        send_table();
    endtask

    // Tests
    task automatic test_good_tables();
        good_table(1'b0, 2'd0, 1'b1, 8'h05, 1'b1, 8'h05);
        good_table(1'b0, 2'd0, 1'b0, 8'h00, 1'b0, 8'hFF);
        good_table(1'b1, 2'd0, 1'b1, 8'h3F, 1'b0, 8'h40);
        good_table(1'b1, 2'd0, 1'b1, BYTE_PREFIX, 1'b1, BYTE_PREFIX);
    endtask

    task automatic test_package_length();
        good_table(1'b0, 2'd1, 1'b0, 8'h07, 1'b1, 8'h11);
        good_table(1'b0, 2'd2, 1'b1, 8'h2A, 1'b0, 8'h15);
        good_table(1'b1, 2'd3, 1'b0, 8'hC3, 1'b0, 8'h3C);
    endtask

    task automatic test_header_errors();
        // wrong signature byte, checksum still good
        put_header();
        table_image[3] ^= 8'h80;
        put_s5(1'b0, 2'd0, 1'b0, 8'h05, 1'b0, 8'h05);
        seal_checksum();
        send_table();
        // wrong signature and wrong checksum: signature wins
        put_header();
        put_s5(1'b0, 2'd0, 1'b0, 8'h05, 1'b0, 8'h05);
        seal_checksum();
        table_image[0] ^= 8'h01;
        send_table();
        // wrong checksum on an otherwise good table
        put_header();
        put_s5(1'b0, 2'd0, 1'b0, 8'h05, 1'b0, 8'h05);
        seal_checksum();
        table_image[20] += 8'd1;
        send_table();
        // wrong checksum without a name
        put_header();
        put_noise(5);
        seal_checksum();
        table_image[30] ^= 8'h10;
        send_table();
        // short tables of one, three and four bytes
        table_image.push_back(signature_reg[7:0]);
        send_table();
        put_header();
        trim_to(3);
        send_table();
        put_header();
        trim_to(4);
        send_table();
    endtask

    task automatic test_scan_errors();
        // no name at all
        put_header();
        put_noise(10);
        seal_checksum();
        send_table();
        // name without name op
        put_header();
        table_image.push_back(8'h33);
        put_name();
        table_image.push_back(PACKAGE_OP);
        put_noise(4);
        seal_checksum();
        send_table();
        // root prefix after a wrong op
        put_header();
        table_image.push_back(8'h07);
        table_image.push_back(CHAR_BACKSLASH);
        put_name();
        put_noise(3);
        seal_checksum();
        send_table();
        // missing package op
        put_header();
        table_image.push_back(NAME_OP);
        put_name();
        table_image.push_back(8'h13);
        put_noise(4);
        seal_checksum();
        send_table();
        // table ends after the first type
        put_header();
        put_s5(1'b0, 2'd0, 1'b1, 8'h05, 1'b0, 8'h06);
        trim_to(table_image.size() - 1);
        seal_checksum();
        send_table();
        // name completes on the last byte
        put_header();
        table_image.push_back(NAME_OP);
        put_name();
        seal_checksum();
        send_table();
        // name inside the header, and one ending just short of the scan window
        put_header();
        trim_to(31);
        put_s5(1'b0, 2'd0, 1'b0, 8'h05, 1'b0, 8'h05);
        seal_checksum();
        send_table();
        put_header();
        trim_to(34);
        put_s5(1'b0, 2'd0, 1'b0, 8'h05, 1'b0, 8'h05);
        seal_checksum();
        send_table();
        // name ending on the first offset that counts
        put_header();
        trim_to(35);
        put_s5(1'b0, 2'd0, 1'b0, 8'h21, 1'b0, 8'h12);
        seal_checksum();
        send_table();
        // long table past the position ceiling
        put_header();
        put_noise(40);
        put_s5(1'b1, 2'd1, 1'b1, 8'h1F, 1'b1, 8'h20);
        seal_checksum();
        send_table();
    endtask

    task automatic test_signature_register();
        logic [31:0] settings [4];
        settings[0] = 32'h0000_0000;
        settings[1] = 32'hFFFF_FFFF;
        settings[2] = $urandom;
        settings[3] = SIG_RESET;
        foreach (settings[i])
        begin
            write_signature(settings[i]);
            good_table(1'b0, 2'd0, 1'b0, 8'h05, 1'b0, 8'h05);
            // a table that still carries the reset signature
            put_header();
            for (int k = 0; k < 4; k++)
                table_image[k] = SIG_RESET[8 * k +: 8];
            put_s5(1'b0, 2'd0, 1'b0, 8'h03, 1'b0, 8'h04);
            seal_checksum();
            send_table();
        end
    endtask

    task automatic build_random_table();
        int kind;
        int s5_at;
        kind = $urandom_range(99);
        if (kind >= 95)
        begin
            put_noise($urandom_range(1, 70));
            return;
        end
        put_header();
        if (kind >= 75 && kind < 83)
        begin
            put_noise($urandom_range(0, 25));
            seal_checksum();
            return;
        end
        if (kind >= 90)
        begin
            trim_to($urandom_range(1, 35));
            if ($urandom_range(3) != 0)
                seal_checksum();
            return;
        end
        put_noise(($urandom_range(3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6));
        s5_at = table_image.size();
        put_s5(1'($urandom_range(1)), 2'($urandom_range(3)), 1'($urandom_range(1)),
               8'($urandom), 1'($urandom_range(1)), 8'($urandom));
        put_noise($urandom_range(0, 4));
        if (kind >= 65 && kind < 75)
        begin
            // break the object: a stray byte, or a cut somewhere inside it
            if ($urandom_range(1) == 1)
                table_image[s5_at + $urandom_range(0, 6)] = 8'($urandom);
            else
                trim_to(s5_at + $urandom_range(1, 12));
        end
        else if (kind >= 83)
        begin
            table_image[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(7));
        end
        if ($urandom_range(9) != 0)
            seal_checksum();
    endtask

    task automatic test_random_tables();
        for (int step = 0; step < 4; step++)
        begin
            case (step)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 52;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 52;
                end
                default:
                begin
                    send_idle_pct = 21;
                    stall_pct     = 21;
                end
            endcase
            if (step == 1)
                write_signature($urandom);
            if (step == 3)
                write_signature(SIG_RESET);
            for (int t = 0; t < RANDOM_TABLES; t++)
            begin
                build_random_table();
                send_table();
                // now and then hold until the scanner has answered everything
                if ($urandom_range(7) == 0)
                    wait_drain();
            end
        end
    endtask

    initial
    begin
        reset_scan();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_good_tables();
        test_package_length();
        test_header_errors();
        test_scan_errors();
        test_signature_register();
        test_random_tables();
        wait_drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
